[design/tmav_pkg.sv]
// ----------------------------------------------------------------------------
// tmav_pkg: shared constants and types of the mesh area/volume core
// Coordinate width, store depth, field widths and the result struct.
// ----------------------------------------------------------------------------
`default_nettype none
package tmav_pkg;
    localparam int VertexDepth = 1024;
    localparam int IndexBits   = 10;
    localparam int CoordBits   = 16;
    localparam int DiffBits    = CoordBits + 1;          // edge component
    localparam int CrossBits   = 2 * DiffBits + 1;       // cross component
    localparam int SqBits      = 2 * CrossBits + 2;      // sum of squares
    localparam int RootBits    = (SqBits + 1) / 2;       // root width
    localparam int DotBits     = CrossBits + CoordBits + 2;
    localparam int AreaBits    = 63;
    localparam int VolBits     = 64;

    typedef logic signed [CoordBits-1:0] coord_t;

    typedef struct packed {
        logic [AreaBits-1:0]       twice_area;
        logic signed [VolBits-1:0] six_volume;
        logic                      overflow;
    } result_t;
endpackage
`default_nettype wire

[design/triangle_mesh_area_volume_core.sv]
// Sequence: a load is written to the vertex memory; a face reads its corners,
//   forms edges, cross product, squares and dot, takes the square root, then accumulates.
// Throughput: one load per cycle while idle; a face holds off the input until
//   accumulated, and a waiting result holds off the input until it is taken.
// Reset: rst_n clears sums, overflow flag and control; the vertex memory is
//   not cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
// triangle_mesh_area_volume_core: mesh surface area and volume accumulator
// Vertex memory, face sequencer, cross/dot products and saturating sums.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_mesh_area_volume_core
    import tmav_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: vertex_index[9:0] coord_x[25:10] coord_y[41:26] coord_z[57:42]
    //        corner_a[67:58] corner_b[77:68] corner_c[87:78]
    input  wire logic [87:0]  s_tdata,
    input  wire logic         s_tuser,   // action
    input  wire logic         s_tlast,   // last_face
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: twice_area[62:0] six_volume[126:63] overflow[127]
    output logic [127:0]      m_tdata
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RDB   = 9'b000000010,
        ST_RDC   = 9'b000000100,
        ST_WAIT  = 9'b000001000,
        ST_DIFF  = 9'b000010000,
        ST_MUL   = 9'b000100000,
        ST_SQ    = 9'b001000000,
        ST_ROOT  = 9'b010000000,
        ST_ACC   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // vertex memory, one write and one read a cycle
    logic [3*CoordBits-1:0] mem [VertexDepth];
    logic [3*CoordBits-1:0] rd_data;
    logic [IndexBits-1:0]   rd_addr;
    logic                   wr_en;

    logic                   s_xfer;
    logic [IndexBits-1:0]   cb_reg, cc_reg;
    logic                   last_reg;
    coord_t                 ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [DiffBits-1:0]  ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [CrossBits-1:0] nx_reg, ny_reg, nz_reg;
    logic [SqBits-1:0]           sq_reg;
    logic signed [DotBits-1:0]   dot_reg;
    logic                        sqrt_start;
    logic                        sqrt_done;
    logic [RootBits-1:0]         root;
    logic [AreaBits-1:0]         area_reg;
    logic signed [VolBits-1:0]   vol_reg;
    logic                        ovf_reg;
    result_t                     out_reg;
    logic                        out_valid_reg;

    assign s_xfer   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign wr_en    = s_xfer && !s_tuser;

    always_comb
    begin
        case (state_reg)
            ST_RDB:  rd_addr = cb_reg;
            ST_RDC:  rd_addr = cc_reg;
            default: rd_addr = s_tdata[67:58];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s_tdata[9:0]] <= s_tdata[57:10];
        rd_data <= mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sqrt_start = 1'b0;
        case (state_reg)
            ST_IDLE: if (s_xfer && s_tuser) state_next = ST_RDB;
            ST_RDB:  state_next = ST_RDC;
            ST_RDC:  state_next = ST_WAIT;
            ST_WAIT: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SQ;
            ST_SQ:
            begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: if (sqrt_done) state_next = ST_ACC;
            ST_ACC:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath: capture corners as reads return, then products
    logic signed [2*DiffBits-1:0] p1, p2, p3, p4, p5, p6;
    logic [2*CrossBits-1:0]       qx, qy, qz;
    logic [CrossBits-1:0]         mx, my, mz;
    always_comb
    begin
        p1 = uy_reg * vz_reg;  p2 = uz_reg * vy_reg;
        p3 = uz_reg * vx_reg;  p4 = ux_reg * vz_reg;
        p5 = ux_reg * vy_reg;  p6 = uy_reg * vx_reg;
        mx = nx_reg[CrossBits-1] ? CrossBits'(-nx_reg) : nx_reg;
        my = ny_reg[CrossBits-1] ? CrossBits'(-ny_reg) : ny_reg;
        mz = nz_reg[CrossBits-1] ? CrossBits'(-nz_reg) : nz_reg;
        qx = mx * mx;  qy = my * my;  qz = mz * mz;
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            cb_reg   <= s_tdata[77:68];
            cc_reg   <= s_tdata[87:78];
            last_reg <= s_tlast;
        end
        case (state_reg)
            ST_RDB:  {az_reg, ay_reg, ax_reg} <= rd_data;
            ST_RDC:  {bz_reg, by_reg, bx_reg} <= rd_data;
            ST_WAIT:
            begin
                ux_reg <= DiffBits'(bx_reg) - DiffBits'(ax_reg);
                uy_reg <= DiffBits'(by_reg) - DiffBits'(ay_reg);
                uz_reg <= DiffBits'(bz_reg) - DiffBits'(az_reg);
                vx_reg <= DiffBits'(coord_t'(rd_data[CoordBits-1:0])) - DiffBits'(ax_reg);
                vy_reg <= DiffBits'(coord_t'(rd_data[2*CoordBits-1:CoordBits]))
                          - DiffBits'(ay_reg);
                vz_reg <= DiffBits'(coord_t'(rd_data[3*CoordBits-1:2*CoordBits]))
                          - DiffBits'(az_reg);
            end
            ST_DIFF:
            begin
                nx_reg <= CrossBits'(p1) - CrossBits'(p2);
                ny_reg <= CrossBits'(p3) - CrossBits'(p4);
                nz_reg <= CrossBits'(p5) - CrossBits'(p6);
            end
            ST_MUL:
            begin
                sq_reg  <= SqBits'(qx) + SqBits'(qy) + SqBits'(qz);
                dot_reg <= DotBits'(nx_reg * ax_reg) + DotBits'(ny_reg * ay_reg)
                           + DotBits'(nz_reg * az_reg);
            end
            default: ;
        endcase
    end

    tmav_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    // saturating sums
    logic [AreaBits:0]          area_sum;
    logic signed [VolBits:0]    vol_sum;
    logic [AreaBits-1:0]        area_new;
    logic signed [VolBits-1:0]  vol_new;
    logic                       ovf_new;
    always_comb
    begin
        area_sum = {1'b0, area_reg} + (AreaBits+1)'(root);
        vol_sum  = {vol_reg[VolBits-1], vol_reg} + (VolBits+1)'(dot_reg);
        ovf_new  = ovf_reg;
        area_new = area_sum[AreaBits-1:0];
        vol_new  = vol_sum[VolBits-1:0];
        if (area_sum[AreaBits])
        begin
            area_new = '1;
            ovf_new  = 1'b1;
        end
        if (vol_sum[VolBits] != vol_sum[VolBits-1])
        begin
            vol_new = vol_sum[VolBits] ? {1'b1, {(VolBits-1){1'b0}}}
                                       : {1'b0, {(VolBits-1){1'b1}}};
            ovf_new = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            area_reg      <= '0;
            vol_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_ACC)
            begin
                if (last_reg)
                begin
                    out_valid_reg <= 1'b1;
                    area_reg <= '0;
                    vol_reg  <= '0;
                    ovf_reg  <= 1'b0;
                end
                else
                begin
                    area_reg <= area_new;
                    vol_reg  <= vol_new;
                    ovf_reg  <= ovf_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACC && last_reg)
        begin
            out_reg.twice_area <= area_new;
            out_reg.six_volume <= vol_new;
            out_reg.overflow   <= ovf_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.overflow, out_reg.six_volume, out_reg.twice_area};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_root_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQ |=> state_reg == ST_ROOT) else $error("root skipped");
endmodule
`default_nettype wire

[design/tmav_isqrt.sv]
// ----------------------------------------------------------------------------
// tmav_isqrt: iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tmav_isqrt
    import tmav_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SqBits-1:0]   radicand,
    output logic                     done,
    output logic [RootBits-1:0]      root
);
    localparam int RemBits = RootBits + 2;
    localparam int CntBits = $clog2(RootBits + 1);
    localparam int NumBits = 2 * RootBits;

    logic [NumBits-1:0]  num_reg,  num_next;   // two radicand bits per step
    logic [RemBits-1:0]  rem_reg,  rem_next;
    logic [RootBits-1:0] root_reg, root_next;
    logic [CntBits-1:0]  cnt_reg,  cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [RemBits-1:0]  trial;
    logic [RemBits-1:0]  shifted;

    // on start load the radicand; else one step: bring down two bits, try 4r+1
    always_comb
    begin
        shifted   = {rem_reg[RemBits-3:0], num_reg[NumBits-1:NumBits-2]};
        trial     = {root_reg, 2'b01};
        num_next  = num_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = NumBits'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CntBits'(RootBits);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NumBits-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[RootBits-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[RootBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntBits'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start) |-> busy_reg) else $error("start not taken");
    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0 || $past(start) == 1'b0)
        else $error("counter left");
endmodule
`default_nettype wire

[tb/tb_triangle_mesh_area_volume_core.sv]
// ----------------------------------------------------------------------------
// tb_triangle_mesh_area_volume_core: self-checking bench of the mesh core
// Loads vertices and streams triangle faces, predicts area and volume sums
// per mesh in a behavioral model, and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_triangle_mesh_area_volume_core
    import tmav_pkg::*;
();

    localparam logic ActLoad = 1'b0;
    localparam logic ActFace = 1'b1;
    localparam logic [62:0] AreaMax = {63{1'b1}};

    typedef struct {
        logic       action;
        logic [9:0] slot;
        coord_t     x, y, z;
        logic [9:0] ca, cb, cc;
        logic       last;
    } mesh_item_t;

    typedef struct {
        logic [62:0]  twice_area;
        logic [63:0]  six_volume;
        logic         overflow;
    } mesh_sums_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;

    triangle_mesh_area_volume_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mesh_item_t pending_items[$];
    mesh_item_t offered;
    mesh_sums_t expected_sums[$];
    int         written_slots[$];
    int         errors;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_requests;
    int         hold_served;
    int         hold_left;

    // Behavioral copy of the core state
    coord_t      vx[VertexDepth];
    coord_t      vy[VertexDepth];
    coord_t      vz[VertexDepth];
    logic [62:0] area_acc;
    longint      vol_acc;
    logic        ovf_acc;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [63:0] isqrt128(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    // Apply one accepted transfer to the model state
    task automatic apply_item(input mesh_item_t it);
        longint             a[3], b[3], c[3], u[3], v[3], n[3];
        logic signed [127:0] w0, w1, w2;
        logic [127:0]       sq;
        logic [63:0]        root;
        longint             dot;
        logic signed [65:0] s, vmax, vmin;
        mesh_sums_t         res;
        if (it.action == ActLoad)
        begin
            vx[it.slot] = it.x;
            vy[it.slot] = it.y;
            vz[it.slot] = it.z;
            return;
        end
        a = '{longint'(vx[it.ca]), longint'(vy[it.ca]), longint'(vz[it.ca])};
        b = '{longint'(vx[it.cb]), longint'(vy[it.cb]), longint'(vz[it.cb])};
        c = '{longint'(vx[it.cc]), longint'(vy[it.cc]), longint'(vz[it.cc])};
        for (int i = 0; i < 3; i++)
        begin
            u[i] = b[i] - a[i];
            v[i] = c[i] - a[i];
        end
        n[0] = u[1] * v[2] - u[2] * v[1];
        n[1] = u[2] * v[0] - u[0] * v[2];
        n[2] = u[0] * v[1] - u[1] * v[0];
        // area: floored magnitude, saturating
        w0 = n[0];
        w1 = n[1];
        w2 = n[2];
        sq = w0 * w0 + w1 * w1 + w2 * w2;
        root = isqrt128(sq);
        if (root > {1'b0, AreaMax - area_acc})
        begin
            area_acc = AreaMax;
            ovf_acc = 1'b1;
        end
        else
            area_acc = area_acc + root[62:0];
        // volume: triple product, saturating
        dot = n[0] * a[0] + n[1] * a[1] + n[2] * a[2];
        vmax = 64'sh7FFF_FFFF_FFFF_FFFF;
        vmin = -vmax - 1;
        s = 66'(vol_acc) + 66'(dot);
        if (s > vmax)
        begin
            vol_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
            ovf_acc = 1'b1;
        end
        else if (s < vmin)
        begin
            vol_acc = 64'sh8000_0000_0000_0000;
            ovf_acc = 1'b1;
        end
        else
            vol_acc = s[63:0];
        if (it.last)
        begin
            res.twice_area = area_acc;
            res.six_volume = vol_acc;
            res.overflow = ovf_acc;
            expected_sums.insert(expected_sums.size(), res);
            area_acc = '0;
            vol_acc = 0;
            ovf_acc = 1'b0;
        end
    endtask

    // Driver: offers queued items, random gaps per phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_item(offered);
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {offered.cc, offered.cb, offered.ca, offered.z, offered.y,
                                offered.x, offered.slot};
                    s_tuser <= offered.action;
                    s_tlast <= offered.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_served <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= 600;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_sums.size() == 0)
                report("unexpected result", m_tdata[63:0], 64'd0);
            else
            begin
                mesh_sums_t e;
                e = expected_sums.pop_front();
                if (m_tdata[62:0] !== e.twice_area)
                    report("twice_area", {1'b0, m_tdata[62:0]}, {1'b0, e.twice_area});
                if (m_tdata[126:63] !== e.six_volume)
                    report("six_volume", m_tdata[126:63], e.six_volume);
                if (m_tdata[127] !== e.overflow)
                    report("overflow", {63'd0, m_tdata[127]}, {63'd0, e.overflow});
            end
        end
    end

    task automatic push_load(input int slot, input int x, input int y, input int z,
                             input logic last);
        mesh_item_t it;
        it.action = ActLoad;
        it.slot = 10'(slot);
        it.x = coord_t'(x);
        it.y = coord_t'(y);
        it.z = coord_t'(z);
        it.ca = 10'($urandom);
        it.cb = 10'($urandom);
        it.cc = 10'($urandom);
        it.last = last;
        pending_items.insert(pending_items.size(), it);
        written_slots.insert(written_slots.size(), slot);
    endtask

    task automatic push_face(input int ca, input int cb, input int cc, input logic last);
        mesh_item_t it;
        it.action = ActFace;
        it.slot = 10'($urandom);
        it.x = coord_t'($urandom);
        it.y = coord_t'($urandom);
        it.z = coord_t'($urandom);
        it.ca = 10'(ca);
        it.cb = 10'(cb);
        it.cc = 10'(cc);
        it.last = last;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic int any_corner();
        return written_slots[$urandom_range(written_slots.size() - 1)];
    endfunction

    // A mesh: a few fresh vertices, then faces, closed by a last face
    task automatic push_mesh();
        int base, nf, nv;
        base = written_slots.size();
        nv = $urandom_range(8, 3);
        for (int i = 0; i < nv; i++)
            push_load($urandom_range(1023), $urandom, $urandom, $urandom,
                      $urandom_range(9) == 0);
        nf = $urandom_range(12, 1);
        for (int i = 0; i < nf; i++)
        begin
            if ($urandom_range(9) == 0)
                push_face(any_corner(), any_corner(), any_corner(), i == nf - 1);
            else
                push_face(written_slots[base + $urandom_range(nv - 1)],
                          written_slots[base + $urandom_range(nv - 1)],
                          written_slots[base + $urandom_range(nv - 1)], i == nf - 1);
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_sums.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        area_acc = '0;
        vol_acc = 0;
        ovf_acc = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coordinate extremes, degenerate faces, last flag on a load
        push_load(0, -32768, -32768, -32768, 1'b0);
        push_load(1023, 32767, 32767, 32767, 1'b0);
        push_load(512, 32767, -32768, 0, 1'b0);
        push_load(5, 0, 0, 0, 1'b1);
        push_load(682, -32768, 32767, -1, 1'b0);
        push_face(0, 1023, 512, 1'b0);
        push_face(5, 0, 1023, 1'b1);
        push_face(0, 0, 0, 1'b1);
        push_face(1023, 0, 512, 1'b1);
        push_face(512, 1023, 0, 1'b0);
        push_face(682, 512, 0, 1'b0);
        push_face(5, 682, 1023, 1'b0);
        push_face(682, 1023, 0, 1'b1);
        push_load(341, 1, -1, 32767, 1'b0);
        push_face(341, 682, 1023, 1'b1);
        // sender pauses until every expected result is back
        drain();

        // Random phases: no idling but one long receiver hold-off, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 78 : (ph == 3) ? 29 : 0;
            recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 29 : 0;
            if (ph == 0)
                hold_requests++;
            while (pending_items.size() < 340)
                push_mesh();
            drain();
        end

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[triangle_mesh_area_volume_core.f]
design/tmav_pkg.sv
design/tmav_isqrt.sv
design/triangle_mesh_area_volume_core.sv
tb/tb_triangle_mesh_area_volume_core.sv
